@@ hdl/ctks_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the class score top-k selector
// no dependencies
package ctks_pkg;

  // fixed field widths
  localparam int TOPC_W    = 7;
  localparam int IDX_OUT_W = 6;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SCORE   = 2'd2;

  // selection modes
  localparam logic MODE_TOP_N      = 1'b0;
  localparam logic MODE_THRESHOLD  = 1'b1;

  // reset value of the top count register
  localparam logic [TOPC_W-1:0] TOP_COUNT_RST = 7'd5;

  // per-cycle command broadcast to every sorter cell
  typedef struct packed {
    logic insert;  // place the incoming pair in the sorted row
    logic pop;     // move the row one place towards the head
  } cell_ctrl_t;

endpackage

@@ hdl/ctks_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces for score input and selected pair output
// depends on ctks_pkg
interface ctks_in_if #(
  parameter int SCORE_BITS = 17
);
  logic                  valid;
  logic                  ready;
  logic [SCORE_BITS-1:0] score;
  logic                  last_class;

  modport source (output valid, score, last_class, input ready);
  modport sink   (input valid, score, last_class, output ready);
endinterface

interface ctks_out_if #(
  parameter int SCORE_BITS = 17
);
  logic                             valid;
  logic                             ready;
  logic [ctks_pkg::IDX_OUT_W-1:0]   class_index;
  logic [SCORE_BITS-1:0]            class_score;
  logic                             last_result;

  modport source (output valid, class_index, class_score, last_result, input ready);
  modport sink   (input valid, class_index, class_score, last_result, output ready);
endinterface

@@ hdl/ctks_cell.sv @@
`timescale 1ns / 1ps
// one slot of the insertion sorter row: holds a (score, index) pair
// depends on ctks_pkg
module ctks_cell #(
  parameter int SCORE_BITS = 17,
  parameter int IDX_W      = 6
) (
  input  logic                       clk,
  input  ctks_pkg::cell_ctrl_t       ctrl,
  input  logic                       slot_free,
  input  logic [SCORE_BITS-1:0]      new_score,
  input  logic [IDX_W-1:0]           new_idx,
  input  logic                       prev_gt,
  input  logic [SCORE_BITS-1:0]      prev_score,
  input  logic [IDX_W-1:0]           prev_idx,
  input  logic [SCORE_BITS-1:0]      next_score,
  input  logic [IDX_W-1:0]           next_idx,
  output logic                       gt,
  output logic [SCORE_BITS-1:0]      score,
  output logic [IDX_W-1:0]           idx
);
  import ctks_pkg::*;

  logic [SCORE_BITS-1:0] score_r, score_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;

  // incoming pair goes in front of this slot; ties keep the older pair ahead
  assign gt = slot_free | (new_score > score_r);

  // take the neighbour's pair, the new pair, or hold
  always_comb begin
    score_nxt = score_r;
    idx_nxt   = idx_r;
    if (ctrl.pop) begin
      score_nxt = next_score;
      idx_nxt   = next_idx;
    end else if (ctrl.insert && gt) begin
      if (prev_gt) begin
        score_nxt = prev_score;
        idx_nxt   = prev_idx;
      end else begin
        score_nxt = new_score;
        idx_nxt   = new_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    idx_r   <= idx_nxt;
  end

  assign score = score_r;
  assign idx   = idx_r;

endmodule

@@ hdl/class_score_top_k_selector_core.sv @@
`timescale 1ns / 1ps
// top level: sorter cell row, load/drain control, config registers
// depends on ctks_pkg, ctks_if, ctks_cell
//
// Scores are loaded one beat per cycle into a row of MAX_CLASSES sorter
// cells; every cell compares the incoming score with its own in the same
// cycle, so the row stays sorted (highest first, lower index first on ties)
// as each score is taken. The beat marked last_class closes the set: input
// then stops and the row drains from its head, one selected pair per cycle
// while the sink takes them, through a registered output stage. Input
// reopens in the cycle after the final selected pair is loaded into that
// stage, or, when nothing is selected, once the drain state sees the head
// pair unselected while the output stage is free. Scores beyond MAX_CLASSES
// in one set are dropped. There is no clearing pass after reset. The user
// writes configuration through cfg_we, cfg_idx and cfg_data (select mode,
// top count, minimum score) only while idle; the block does not enforce it.
module class_score_top_k_selector_core #(
  parameter int MAX_CLASSES = 64,
  parameter int SCORE_BITS  = 17
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ctks_in_if.sink                             in_beat,
  ctks_out_if.source                          out_beat,
  input  logic                                cfg_we,
  input  logic [ctks_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [SCORE_BITS-1:0]               cfg_data
);
  import ctks_pkg::*;

  localparam int IDX_W = $clog2(MAX_CLASSES);
  localparam int CNT_W = $clog2(MAX_CLASSES + 1);

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      left_r, left_nxt;
  logic [TOPC_W-1:0]     top_left_r, top_left_nxt;
  logic                  mode_r;
  logic [TOPC_W-1:0]     top_count_r;
  logic [SCORE_BITS-1:0] min_score_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]      out_idx_r;
  logic [SCORE_BITS-1:0] out_score_r;
  logic                  out_last_r;

  logic                  in_fire, full, out_free, head_ok, next_ok;
  logic [CNT_W-1:0]      loaded;
  logic [TOPC_W-1:0]     loaded_w;
  cell_ctrl_t            ctrl;

  logic [SCORE_BITS-1:0] cell_score [MAX_CLASSES];
  logic [IDX_W-1:0]      cell_idx   [MAX_CLASSES];
  logic                  cell_gt    [MAX_CLASSES];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_TOP_N;
      top_count_r <= TOP_COUNT_RST;
      min_score_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SELECT_MODE: mode_r      <= cfg_data[0];
        REG_TOP_COUNT:   top_count_r <= cfg_data[TOPC_W-1:0];
        REG_MIN_SCORE:   min_score_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input side
  assign in_beat.ready = (state_r == ST_LOAD);
  assign in_fire       = in_beat.valid && (state_r == ST_LOAD);
  assign full          = (count_r == CNT_W'(MAX_CLASSES));
  assign ctrl.insert   = in_fire && !full;
  assign loaded        = count_r + CNT_W'(ctrl.insert);
  assign loaded_w      = TOPC_W'(loaded);

  // drain side: is the head pair selected, and the one behind it
  assign out_free = !out_valid_r || out_beat.ready;
  assign head_ok  = (left_r != '0) &&
                    ((mode_r == MODE_THRESHOLD) ? (cell_score[0] >= min_score_r)
                                                : (top_left_r != '0));
  assign next_ok  = (left_r > CNT_W'(1)) &&
                    ((mode_r == MODE_THRESHOLD) ? (cell_score[1] >= min_score_r)
                                                : (top_left_r > TOPC_W'(1)));
  assign ctrl.pop = (state_r == ST_DRAIN) && out_free && head_ok;

  // sorter row
  for (genvar g = 0; g < MAX_CLASSES; g++) begin : g_cell
    logic                  prev_gt;
    logic [SCORE_BITS-1:0] prev_score, next_score;
    logic [IDX_W-1:0]      prev_idx, next_idx;

    if (g == 0) begin : g_head
      assign prev_gt    = 1'b0;
      assign prev_score = in_beat.score;
      assign prev_idx   = IDX_W'(count_r);
    end else begin : g_body
      assign prev_gt    = cell_gt[g-1];
      assign prev_score = cell_score[g-1];
      assign prev_idx   = cell_idx[g-1];
    end

    if (g == MAX_CLASSES - 1) begin : g_tail
      assign next_score = cell_score[g];
      assign next_idx   = cell_idx[g];
    end else begin : g_inner
      assign next_score = cell_score[g+1];
      assign next_idx   = cell_idx[g+1];
    end

    ctks_cell #(
      .SCORE_BITS (SCORE_BITS),
      .IDX_W      (IDX_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .slot_free  (CNT_W'(g) >= count_r),
      .new_score  (in_beat.score),
      .new_idx    (IDX_W'(count_r)),
      .prev_gt    (prev_gt),
      .prev_score (prev_score),
      .prev_idx   (prev_idx),
      .next_score (next_score),
      .next_idx   (next_idx),
      .gt         (cell_gt[g]),
      .score      (cell_score[g]),
      .idx        (cell_idx[g])
    );
  end

  // load/drain sequencing
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    left_nxt      = left_r;
    top_left_nxt  = top_left_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (in_beat.last_class) begin
            count_nxt    = '0;
            left_nxt     = loaded;
            top_left_nxt = (top_count_r < loaded_w) ? top_count_r : loaded_w;
            state_nxt    = ST_DRAIN;
          end else begin
            count_nxt = loaded;
          end
        end
        if (out_beat.ready) begin
          out_valid_nxt = 1'b0;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = head_ok;
          if (head_ok) begin
            left_nxt = left_r - CNT_W'(1);
            if (top_left_r != '0) begin
              top_left_nxt = top_left_r - TOPC_W'(1);
            end
            if (!next_ok) begin
              state_nxt = ST_LOAD;
            end
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      left_r      <= '0;
      top_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      top_left_r  <= top_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      out_idx_r   <= cell_idx[0];
      out_score_r <= cell_score[0];
      out_last_r  <= !next_ok;
    end
  end

  assign out_beat.valid       = out_valid_r;
  assign out_beat.class_index = IDX_OUT_W'(out_idx_r);
  assign out_beat.class_score = out_score_r;
  assign out_beat.last_result = out_last_r;

  // fill count never passes the row length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_CLASSES))
    else $error("fill count beyond row length");

  // closing beat starts a fresh set and the drain
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_beat.last_class |=> (count_r == '0) && (state_r == ST_DRAIN))
    else $error("closing beat did not start drain");

  // top-n budget never exceeds pairs still in the row
  a_budget: assert property (@(posedge clk) disable iff (!rst_n)
    top_left_r <= TOPC_W'(left_r))
    else $error("top-n budget above remaining pairs");

  // a pop only happens while draining a non-empty row
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> (state_r == ST_DRAIN) && (left_r != '0) && !ctrl.insert)
    else $error("row popped outside drain");

endmodule

@@ test/ctks_pick_checker.sv @@
`timescale 1ns / 1ps
// watches the score and selected pair channels, ranks scores and checks every pair beat
// depends on ctks_pkg and ctks_if
module ctks_pick_checker #(
  parameter int MAX_CLASSES = 64,
  parameter int SCORE_BITS  = 17
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ctks_in_if                             score_mon,
  ctks_out_if                            pick_mon,
  input  logic                           cfg_we,
  input  logic [ctks_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [SCORE_BITS-1:0]          cfg_data,
  output int                             error_count,
  output int                             pending
);
  import ctks_pkg::*;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]  idx;
    logic [SCORE_BITS-1:0] score;
    logic                  tail;
  } pick_t;

  // own copy of the registers
  logic                  sel_mode;
  logic [TOPC_W-1:0]     top_n;
  logic [SCORE_BITS-1:0] floor_score;

  // ranked row of the set being loaded, highest score first
  logic [SCORE_BITS-1:0] ranked_score [MAX_CLASSES];
  logic [IDX_OUT_W-1:0]  ranked_class [MAX_CLASSES];
  int                    ranked_total;

  pick_t pick_q[$];

  // insertion keeps earlier classes ahead on equal scores; a full row drops the score
  task automatic rank_insert(input logic [SCORE_BITS-1:0] s);
    int pos;
    if (ranked_total >= MAX_CLASSES) return;
    pos = ranked_total;
    while (pos > 0 && ranked_score[pos-1] < s) begin
      ranked_score[pos] = ranked_score[pos-1];
      ranked_class[pos] = ranked_class[pos-1];
      pos--;
    end
    ranked_score[pos] = s;
    ranked_class[pos] = ranked_total[IDX_OUT_W-1:0];
    ranked_total++;
  endtask

  // set closed: queue the selected head of the row, then empty it
  task automatic close_set();
    int n;
    if (sel_mode == MODE_TOP_N) begin
      n = (int'(top_n) < ranked_total) ? int'(top_n) : ranked_total;
    end else begin
      n = 0;
      while (n < ranked_total && ranked_score[n] >= floor_score) n++;
    end
    for (int k = 0; k < n; k++)
      pick_q.insert(pick_q.size(), pick_t'{ranked_class[k], ranked_score[k], (k == n - 1)});
    ranked_total = 0;
  endtask

  // compare one pair beat with the oldest expected pair
  task automatic check_pick();
    pick_t want;
    if (pick_q.size() == 0) begin
      $display("%0t: unexpected pair beat, got index %0d score %0d last %0b", $time,
               pick_mon.class_index, pick_mon.class_score, pick_mon.last_result);
      error_count++;
      return;
    end
    want = pick_q.pop_front();
    if (pick_mon.class_index !== want.idx) begin
      $display("%0t: class_index expected %0d got %0d", $time, want.idx,
               pick_mon.class_index);
      error_count++;
    end
    if (pick_mon.class_score !== want.score) begin
      $display("%0t: class_score expected %0d got %0d", $time, want.score,
               pick_mon.class_score);
      error_count++;
    end
    if (pick_mon.last_result !== want.tail) begin
      $display("%0t: last_result expected %0b got %0b", $time, want.tail,
               pick_mon.last_result);
      error_count++;
    end
  endtask

  // everything sampled at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      sel_mode     = MODE_TOP_N;
      top_n        = TOP_COUNT_RST;
      floor_score  = '0;
      ranked_total = 0;
      pick_q.delete();
      pending     <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_SELECT_MODE: sel_mode    = cfg_data[0];
          REG_TOP_COUNT:   top_n       = cfg_data[TOPC_W-1:0];
          REG_MIN_SCORE:   floor_score = cfg_data;
          default: ;
        endcase
      end
      if (pick_mon.valid && pick_mon.ready) check_pick();
      if (score_mon.valid && score_mon.ready) begin
        rank_insert(score_mon.score);
        if (score_mon.last_class) close_set();
      end
      pending <= pick_q.size();
    end
  end

endmodule

@@ test/class_score_top_k_selector_core_tb.sv @@
`timescale 1ns / 1ps
// top of the selector testbench: clock, reset, score and config stimulus, verdict
// depends on ctks_pkg, ctks_if, ctks_pick_checker and the selector core
module class_score_top_k_selector_core_tb;
  import ctks_pkg::*;

  localparam int MAX_CLASSES = 64;
  localparam int SCORE_BITS  = 17;
  localparam int ITEM_TARGET = 480;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [SCORE_BITS-1:0] cfg_data;
  int                    err_cnt;
  int                    pending;
  int                    loaded;
  bit                    steady;

  ctks_in_if  #(.SCORE_BITS(SCORE_BITS)) score_ch ();
  ctks_out_if #(.SCORE_BITS(SCORE_BITS)) pick_ch ();

  class_score_top_k_selector_core #(
    .MAX_CLASSES(MAX_CLASSES),
    .SCORE_BITS (SCORE_BITS)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_beat (score_ch),
    .out_beat(pick_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  ctks_pick_checker #(
    .MAX_CLASSES(MAX_CLASSES),
    .SCORE_BITS (SCORE_BITS)
  ) pick_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .score_mon  (score_ch),
    .pick_mon   (pick_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .error_count(err_cnt),
    .pending    (pending)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one score beat, after a random gap unless in a steady stretch
  task automatic push_score(input logic [SCORE_BITS-1:0] s, input logic lc);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      score_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    score_ch.valid      <= 1'b1;
    score_ch.score      <= s;
    score_ch.last_class <= lc;
    do @(posedge clk); while (!score_ch.ready);
  endtask

  // hold off input until every expected pair has come and the block has settled
  task automatic wait_drained();
    score_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // write all three registers while idle
  task automatic program_regs(input logic [SCORE_BITS-1:0] mode_d,
                              input logic [SCORE_BITS-1:0] count_d,
                              input logic [SCORE_BITS-1:0] floor_d);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_SELECT_MODE;
    cfg_data <= mode_d;
    @(posedge clk);
    cfg_idx  <= REG_TOP_COUNT;
    cfg_data <= count_d;
    @(posedge clk);
    cfg_idx  <= REG_MIN_SCORE;
    cfg_data <= floor_d;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [SCORE_BITS-1:0] pick_score(input int style);
    case (style)
      0:       return SCORE_BITS'($urandom_range(0, 17'h1FFFF));
      1:       return SCORE_BITS'($urandom_range(0, 3) * 32768);
      2:       return SCORE_BITS'($urandom_range(0, 65536));
      default: begin
        case ($urandom_range(0, 4))
          0:       return 17'd0;
          1:       return 17'd1;
          2:       return 17'd65535;
          3:       return 17'd65536;
          default: return 17'h1FFFF;
        endcase
      end
    endcase
  endfunction

  // one set of len scores, the final one marked
  task automatic load_set(input int len, input int style);
    for (int k = 0; k < len; k++) begin
      push_score(pick_score(style), (k == len - 1));
      if (k < MAX_CLASSES) loaded++;
    end
  endtask

  // result side: random stall per beat, steady stretches with ready held high
  initial begin
    int stall;
    pick_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        pick_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pick_ch.ready <= 1'b1;
      do @(posedge clk); while (!pick_ch.valid);
    end
  end

  // stimulus and verdict
  initial begin
    int len;
    int r;
    logic [TOPC_W-1:0]     cnt;
    logic [SCORE_BITS-1:0] floor_v;
    score_ch.valid      <= 1'b0;
    score_ch.score      <= '0;
    score_ch.last_class <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= REG_SELECT_MODE;
    cfg_data <= '0;
    rst_n    <= 1'b0;
    steady    = 1'b0;
    loaded    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, top five: extremes, scores above one, ties
    push_score(17'd0, 1'b0);
    push_score(17'h1FFFF, 1'b0);
    push_score(17'd65536, 1'b0);
    push_score(17'd0, 1'b0);
    push_score(17'd1, 1'b0);
    push_score(17'd65536, 1'b1);
    // single class, count clamped to one
    push_score(17'd40000, 1'b1);

    // zero top count, junk in the upper register bits
    program_regs(17'h1FFFE, 17'h1FF80, 17'h1FFFF);
    push_score(17'd100, 1'b0);
    push_score(17'd200, 1'b0);
    push_score(17'd300, 1'b1);

    // threshold at one: scores at or above the floor pass, the rest do not
    program_regs(17'h1FFFF, 17'd64, 17'd65536);
    push_score(17'd65535, 1'b0);
    push_score(17'd65536, 1'b0);
    push_score(17'h1FFFF, 1'b0);
    push_score(17'd0, 1'b0);
    push_score(17'd65536, 1'b1);
    // nothing passes the threshold
    push_score(17'd1, 1'b0);
    push_score(17'd65535, 1'b1);

    // zero threshold, all equal
    program_regs(17'd1, 17'd127, 17'd0);
    push_score(17'd5, 1'b0);
    push_score(17'd5, 1'b0);
    push_score(17'd5, 1'b1);

    // top count far above the set size
    program_regs(17'd0, 17'd127, 17'h1FFFF);
    push_score(17'd7, 1'b0);
    push_score(17'd9, 1'b0);
    push_score(17'd8, 1'b0);
    push_score(17'd9, 1'b1);

    // random phases: fresh settings, then a few sets each
    while (loaded < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0:       cnt = 7'd0;
        1:       cnt = 7'd1;
        2:       cnt = 7'd64;
        3:       cnt = 7'd127;
        4:       cnt = TOPC_W'($urandom_range(1, 12));
        default: cnt = TOPC_W'($urandom_range(0, 127));
      endcase
      case ($urandom_range(0, 4))
        0:       floor_v = 17'd0;
        1:       floor_v = 17'd65536;
        2:       floor_v = 17'h1FFFF;
        3:       floor_v = SCORE_BITS'($urandom_range(0, 65535));
        default: floor_v = SCORE_BITS'($urandom());
      endcase
      program_regs(SCORE_BITS'(($urandom() & 32'h1FFFE) | $urandom_range(0, 1)),
                   SCORE_BITS'(($urandom() & 32'h1FF80) | cnt), floor_v);
      repeat ($urandom_range(1, 6)) begin
        steady = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 19);
        // mostly short sets, a few filling the row or running past it
        if (r == 0)
          len = $urandom_range(64, 70);
        else if (r <= 2)
          len = $urandom_range(20, 63);
        else
          len = $urandom_range(1, 12);
        load_set(len, $urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0) wait_drained();
      end
    end

    steady = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
